// ===== src/lirp_pkg.sv =====
package lirp_pkg;

  localparam int unsigned FracBits       = 12;
  localparam int unsigned SampleW        = 16;
  localparam int unsigned PosW           = 20;
  localparam int unsigned StepW          = 15;
  localparam int unsigned CountW         = 13;
  localparam int unsigned CfgDataW       = 15;
  localparam int unsigned CfgIdxW        = 2;
  localparam int unsigned MaxBlockFrames = 4096;
  localparam int unsigned MinStep        = ((1 << FracBits) + 63) / 64;
  localparam int unsigned ProdW          = SampleW + FracBits + 2;
  localparam int unsigned SumW           = SampleW + FracBits + 3;

  localparam logic [PosW-1:0]   OnePos = PosW'(1 << FracBits);
  localparam logic [CountW-1:0] MaxLimit = CountW'(MaxBlockFrames);
  localparam logic [StepW-1:0]  MinStepV = StepW'(MinStep);

  localparam logic [CfgIdxW-1:0] RegStereoMode    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegStepRatio     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFramesPerBlk  = 2'd2;

  typedef struct packed {
    logic load;
    logic mul;
    logic emit;
    logic finish;
  } lirp_cmd_t;

  typedef struct packed {
    logic active;
    logic entered;
    logic out_free;
  } lirp_sts_t;

endpackage

// ===== src/lirp_ctrl.sv =====
module lirp_ctrl import lirp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lirp_sts_t sts_i,
  output lirp_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOP,
    S_OUT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_LOOP;
        end
      end
      S_LOOP: begin
        if (sts_i.entered && sts_i.active) begin
          cmd_o.mul = 1'b1;
          state_d   = S_OUT;
        end else begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_LOOP;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

// ===== src/lirp_dp.sv =====
module lirp_dp import lirp_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_idx_i,
  input  logic [CfgDataW-1:0]        cfg_wdata_i,
  input  logic signed [SampleW-1:0]  sample_left_i,
  input  logic signed [SampleW-1:0]  sample_right_i,
  input  logic                       block_start_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [SampleW-1:0]  out_left_o,
  output logic signed [SampleW-1:0]  out_right_o,
  output logic                       last_of_run_o,
  output logic                       block_done_o,
  input  lirp_cmd_t                  cmd_i,
  output lirp_sts_t                  sts_o
);

  logic                      stereo_q;
  logic [StepW-1:0]          step_ratio_q;
  logic [CountW-1:0]         fpb_q;
  logic [StepW-1:0]          step;
  logic [CountW-1:0]         limit;

  logic signed [SampleW-1:0] prev_l_q, prev_r_q, cur_l_q, cur_r_q;
  logic [PosW-1:0]           pos_q;
  logic [CountW-1:0]         count_q;
  logic                      have_prev_q;
  logic                      entered_q;

  logic signed [ProdW-1:0]   prod_l_q, prod_r_q;
  logic                      last_q, done_q;

  logic                      out_valid_q;
  logic signed [SampleW-1:0] out_l_q, out_r_q;
  logic                      out_last_q, out_done_q;

  logic [PosW-1:0]           pos_next;
  logic [CountW-1:0]         count_next;
  logic signed [SampleW:0]   diff_l, diff_r;
  logic signed [FracBits:0]  frac;
  logic signed [SampleW-1:0] res_l, res_r;

  assign step  = (step_ratio_q < MinStepV) ? MinStepV : step_ratio_q;
  assign limit = (fpb_q > MaxLimit) ? MaxLimit : fpb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stereo_q     <= 1'b1;
      step_ratio_q <= StepW'(1 << FracBits);
      fpb_q        <= CountW'(1024);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegStereoMode:   stereo_q     <= cfg_wdata_i[0];
        RegStepRatio:    step_ratio_q <= cfg_wdata_i[StepW-1:0];
        RegFramesPerBlk: fpb_q        <= cfg_wdata_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign pos_next   = pos_q + PosW'(step);
  assign count_next = count_q + CountW'(1);
  assign frac       = {1'b0, pos_q[FracBits-1:0]};
  assign diff_l     = {cur_l_q[SampleW-1], cur_l_q} - {prev_l_q[SampleW-1], prev_l_q};
  assign diff_r     = {cur_r_q[SampleW-1], cur_r_q} - {prev_r_q[SampleW-1], prev_r_q};

  // value = (prev * one + diff * f) / one, truncated toward zero
  function automatic logic signed [SampleW-1:0] scale_down(
    input logic signed [SampleW-1:0] prev,
    input logic signed [ProdW-1:0]   prod
  );
    logic signed [SumW-1:0] s;
    logic signed [SumW-1:0] adj;
    s   = (SumW'(prev) <<< FracBits) + SumW'(prod);
    adj = s + (s[SumW-1] ? SumW'((1 << FracBits) - 1) : SumW'(0));
    return adj[FracBits +: SampleW];
  endfunction

  assign res_l = scale_down(prev_l_q, prod_l_q);
  assign res_r = stereo_q ? scale_down(prev_r_q, prod_r_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      count_q     <= '0;
      have_prev_q <= 1'b0;
      entered_q   <= 1'b0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
    end else begin
      if (cmd_i.load) begin
        entered_q <= !block_start_i && have_prev_q && (count_q < limit);
        if (block_start_i) begin
          pos_q       <= '0;
          count_q     <= '0;
          have_prev_q <= 1'b0;
        end
      end
      if (cmd_i.mul) begin
        pos_q   <= pos_next;
        count_q <= count_next;
      end
      if (cmd_i.finish) begin
        if (entered_q && pos_q >= OnePos) begin
          pos_q <= pos_q - OnePos;
        end
        prev_l_q    <= cur_l_q;
        prev_r_q    <= cur_r_q;
        have_prev_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_l_q <= sample_left_i;
      cur_r_q <= sample_right_i;
    end
    if (cmd_i.mul) begin
      prod_l_q <= ProdW'(diff_l) * ProdW'(frac);
      prod_r_q <= ProdW'(diff_r) * ProdW'(frac);
      last_q   <= (pos_next >= OnePos) || (count_next == limit);
      done_q   <= (count_next == limit);
    end
    if (cmd_i.emit) begin
      out_l_q    <= res_l;
      out_r_q    <= res_r;
      out_last_q <= last_q;
      out_done_q <= done_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.active   = (pos_q < OnePos) && (count_q < limit);
  assign sts_o.entered  = entered_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_left_o    = out_l_q;
  assign out_right_o   = out_r_q;
  assign last_of_run_o = out_last_q;
  assign block_done_o  = out_done_q;

  a_mul_needs_prev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul |-> have_prev_q && (count_q < limit))
    else $error("interpolation started without a previous frame");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !(out_valid_q && !out_ready_i))
    else $error("pending result overwritten");

  a_count_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mul |=> count_q != '0)
    else $error("output count did not advance");

  a_finish_commits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> have_prev_q)
    else $error("frame not kept as previous");

endmodule

// ===== src/linear_interp_pitch_resampler.sv =====
// Linear interpolation resampler for 16-bit mono or stereo frames. Each input item
// is loaded and then finished; for every result it produces, the controller steps
// the single interpolation unit once, through the multiply and then the scale and
// round into the output register. A finished result sits in an output register, so
// the next multiply proceeds while it waits; a new input item is taken only after
// all results of the current one are in or through that register. Configuration is
// written through a plain write port: index 0 stereo mode, 1 step ratio (Q3.12),
// 2 frames per block.
module linear_interp_pitch_resampler import lirp_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CfgDataW-1:0]       cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [SampleW-1:0] sample_left_i,
  input  logic signed [SampleW-1:0] sample_right_i,
  input  logic                      block_start_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [SampleW-1:0] out_left_o,
  output logic signed [SampleW-1:0] out_right_o,
  output logic                      last_of_run_o,
  output logic                      block_done_o
);

  lirp_cmd_t cmd;
  lirp_sts_t sts;

  lirp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lirp_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .sample_left_i  (sample_left_i),
    .sample_right_i (sample_right_i),
    .block_start_i  (block_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_left_o     (out_left_o),
    .out_right_o    (out_right_o),
    .last_of_run_o  (last_of_run_o),
    .block_done_o   (block_done_o),
    .cmd_i          (cmd),
    .sts_o          (sts)
  );

endmodule

// ===== verif/linear_interp_pitch_resampler_tb.sv =====
module linear_interp_pitch_resampler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lirp_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned Phases = 10;
  localparam int unsigned ItemsPerPhase = 31;
  localparam int unsigned MaxRun = 64;
  localparam longint OneL = longint'(1) << FracBits;

  typedef struct {
    logic signed [SampleW-1:0] left;
    logic signed [SampleW-1:0] right;
    logic                      last;
    logic                      done;
  } out_t;

  typedef struct {
    bit                        setup;
    bit                        stereo;
    logic [StepW-1:0]          step;
    logic [CountW-1:0]         fpb;
    logic signed [SampleW-1:0] l;
    logic signed [SampleW-1:0] r;
    logic                      bs;
    bit                        pinned;
    int                        n;
    logic signed [SampleW-1:0] el;
    logic signed [SampleW-1:0] er;
  } row_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CfgIdxW-1:0]        cfg_idx_i;
  logic [CfgDataW-1:0]       cfg_wdata_i;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic signed [SampleW-1:0] sample_left_i;
  logic signed [SampleW-1:0] sample_right_i;
  logic                      block_start_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [SampleW-1:0] out_left_o;
  logic signed [SampleW-1:0] out_right_o;
  logic                      last_of_run_o;
  logic                      block_done_o;

  linear_interp_pitch_resampler u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_left_i  (sample_left_i),
    .sample_right_i (sample_right_i),
    .block_start_i  (block_start_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_left_o     (out_left_o),
    .out_right_o    (out_right_o),
    .last_of_run_o  (last_of_run_o),
    .block_done_o   (block_done_o)
  );

  // predictor copy of config and state
  bit                        cfg_stereo;
  logic [StepW-1:0]          cfg_step;
  logic [CountW-1:0]         cfg_fpb;
  logic signed [SampleW-1:0] st_prev_l;
  logic signed [SampleW-1:0] st_prev_r;
  logic [PosW-1:0]           st_pos;
  bit                        st_have_prev;
  logic [CountW-1:0]         st_count;

  out_t        owed_outputs[$];
  int unsigned mismatches;
  int unsigned cycles;
  bit          steady;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  function automatic logic signed [SampleW-1:0] blend(input logic signed [SampleW-1:0] a,
                                                      input logic signed [SampleW-1:0] b,
                                                      input logic [FracBits-1:0] f);
    longint s;
    s = longint'(a) * (OneL - longint'(f)) + longint'(b) * longint'(f);
    return SampleW'(s / OneL);
  endfunction

  task automatic resample_frame(input logic signed [SampleW-1:0] cl,
                                input logic signed [SampleW-1:0] cr,
                                input logic bs, output int n, output out_t first);
    out_t              run [MaxRun];
    logic [CountW-1:0] lim;
    logic [StepW-1:0]  stp;
    logic [FracBits-1:0] f;
    n = 0;
    first = '{default: '0};
    lim = (cfg_fpb > MaxLimit) ? MaxLimit : cfg_fpb;
    stp = (cfg_step < MinStepV) ? MinStepV : cfg_step;
    if (bs) begin
      st_pos = '0;
      st_count = '0;
      st_have_prev = 1'b0;
    end
    if (st_have_prev && st_count < lim) begin
      while (st_pos < OnePos && st_count < lim && n < MaxRun) begin
        f = st_pos[FracBits-1:0];
        st_count++;
        run[n].left = blend(st_prev_l, cl, f);
        run[n].right = cfg_stereo ? blend(st_prev_r, cr, f) : '0;
        run[n].last = 1'b0;
        run[n].done = (st_count == lim);
        n++;
        st_pos = st_pos + PosW'(stp);
      end
      if (n > 0) begin
        run[n-1].last = 1'b1;
        first = run[0];
      end
      for (int i = 0; i < n; i++) owed_outputs.push_back(run[i]);
      if (st_pos >= OnePos) st_pos = st_pos - OnePos;
    end
    st_prev_l = cl;
    st_prev_r = cr;
    st_have_prev = 1'b1;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic offer_frame(input logic signed [SampleW-1:0] l,
                             input logic signed [SampleW-1:0] r,
                             input logic bs, output int n, output out_t first);
    while (!steady && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_left_i  <= l;
    sample_right_i <= r;
    block_start_i  <= bs;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    resample_frame(l, r, bs, n, first);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (owed_outputs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apply_setting(input bit stereo, input logic [StepW-1:0] step,
                               input logic [CountW-1:0] fpb);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= RegStereoMode;
    cfg_wdata_i <= CfgDataW'(stereo);
    @(negedge clk_i);
    cfg_idx_i   <= RegStepRatio;
    cfg_wdata_i <= CfgDataW'(step);
    @(negedge clk_i);
    cfg_idx_i   <= RegFramesPerBlk;
    cfg_wdata_i <= CfgDataW'(fpb);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_stereo = stereo;
    cfg_step = step;
    cfg_fpb = fpb;
  endtask

  function automatic row_t cfg_row(input bit stereo, input logic [StepW-1:0] step,
                                   input logic [CountW-1:0] fpb);
    row_t row;
    row = '{default: '0};
    row.setup = 1'b1;
    row.stereo = stereo;
    row.step = step;
    row.fpb = fpb;
    return row;
  endfunction

  function automatic row_t frame_row(input logic signed [SampleW-1:0] l,
                                     input logic signed [SampleW-1:0] r, input logic bs,
                                     input bit pinned, input int n,
                                     input logic signed [SampleW-1:0] el,
                                     input logic signed [SampleW-1:0] er);
    row_t row;
    row = '{default: '0};
    row.l = l;
    row.r = r;
    row.bs = bs;
    row.pinned = pinned;
    row.n = n;
    row.el = el;
    row.er = er;
    return row;
  endfunction

  function automatic logic signed [SampleW-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return SampleW'($urandom);
    endcase
  endfunction

  always @(negedge clk_i) begin
    out_ready_i <= steady ? 1'b1 : ($urandom_range(99) >= 33);
  end

  always @(posedge clk_i) begin : out_check
    out_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (owed_outputs.size() == 0) begin
        flag_mismatch($sformatf("unexpected item l=%0d r=%0d", out_left_o, out_right_o));
      end else begin
        want = owed_outputs.pop_front();
        if (out_left_o !== want.left)
          flag_mismatch($sformatf("out_left %0d, want %0d", out_left_o, want.left));
        if (out_right_o !== want.right)
          flag_mismatch($sformatf("out_right %0d, want %0d", out_right_o, want.right));
        if (last_of_run_o !== want.last)
          flag_mismatch($sformatf("last_of_run %b, want %b", last_of_run_o, want.last));
        if (block_done_o !== want.done)
          flag_mismatch($sformatf("block_done %b, want %b", block_done_o, want.done));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("linear_interp_pitch_resampler_tb failed");
      $finish;
    end
  end

  initial begin : stimulus
    row_t              plan[$];
    int                n;
    out_t              first;
    bit                stereo;
    logic [StepW-1:0]  step;
    logic [CountW-1:0] fpb;
    logic              bs;

    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    sample_left_i  = '0;
    sample_right_i = '0;
    block_start_i  = 1'b0;
    out_ready_i    = 1'b0;
    steady         = 1'b0;
    mismatches     = 0;
    cycles         = 0;

    cfg_stereo   = 1'b1;
    cfg_step     = StepW'(4096);
    cfg_fpb      = CountW'(1024);
    st_prev_l    = '0;
    st_prev_r    = '0;
    st_pos       = '0;
    st_have_prev = 1'b0;
    st_count     = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings, first frame only stored, output 0 equals it
    plan.push_back(frame_row(32767, -32768, 1, 1, 0, 0, 0));
    plan.push_back(frame_row(-32768, 32767, 0, 1, 1, 32767, -32768));
    plan.push_back(frame_row(0, 0, 0, 1, 1, -32768, 32767));
    // mono, step 0 raised to the minimum, block length above the limit
    plan.push_back(cfg_row(0, 0, 8191));
    plan.push_back(frame_row(1000, 500, 1, 1, 0, 0, 0));
    plan.push_back(frame_row(-1000, 7, 0, 1, 64, 1000, 0));
    plan.push_back(frame_row(32767, 32767, 0, 1, 64, -1000, 0));
    // step of two frames, block of three then complete
    plan.push_back(cfg_row(1, 8192, 3));
    plan.push_back(frame_row(100, -100, 1, 1, 0, 0, 0));
    plan.push_back(frame_row(200, -200, 0, 1, 1, 100, -100));
    plan.push_back(frame_row(300, -300, 0, 1, 0, 0, 0));
    plan.push_back(frame_row(400, -400, 0, 1, 1, 300, -300));
    plan.push_back(frame_row(500, -500, 0, 1, 0, 0, 0));
    plan.push_back(frame_row(600, -600, 0, 1, 1, 500, -500));
    plan.push_back(frame_row(700, -700, 0, 1, 0, 0, 0));
    plan.push_back(frame_row(800, -800, 0, 1, 0, 0, 0));
    // zero block length gives nothing
    plan.push_back(cfg_row(1, 64, 0));
    plan.push_back(frame_row(-5, 5, 1, 1, 0, 0, 0));
    plan.push_back(frame_row(5, -5, 0, 1, 0, 0, 0));
    // fractional positions between extremes
    plan.push_back(cfg_row(1, 1365, 4096));
    plan.push_back(frame_row(-32768, 32767, 1, 0, 0, 0, 0));
    plan.push_back(frame_row(32767, -32768, 0, 0, 0, 0, 0));
    plan.push_back(frame_row(-1, 1, 0, 0, 0, 0, 0));
    plan.push_back(frame_row(12345, -12345, 0, 0, 0, 0, 0));
    plan.push_back(cfg_row(1, 32767, 8191));
    plan.push_back(frame_row(-32768, -32768, 1, 0, 0, 0, 0));
    plan.push_back(frame_row(32767, 32767, 0, 0, 0, 0, 0));

    foreach (plan[i]) begin
      if (plan[i].setup) begin
        settle();
        apply_setting(plan[i].stereo, plan[i].step, plan[i].fpb);
      end else begin
        offer_frame(plan[i].l, plan[i].r, plan[i].bs, n, first);
        if (plan[i].pinned && (n != plan[i].n ||
            (n > 0 && (first.left != plan[i].el || first.right != plan[i].er))))
          flag_mismatch($sformatf("row %0d predicted %0d items, first l=%0d r=%0d",
                                  i, n, first.left, first.right));
      end
    end
    settle();

    for (int phase = 0; phase < Phases; phase++) begin
      stereo = (phase < 4) ? phase[0] : bit'($urandom_range(1));
      case (phase)
        0: begin step = 0;     fpb = 8191; end
        1: begin step = 32767; fpb = 1;    end
        2: begin step = 16384; fpb = 4097; end
        3: begin step = 64;    fpb = 4096; end
        default: begin
          case ($urandom_range(7))
            0: step = StepW'($urandom_range(63));
            1: step = StepW'($urandom_range(32767, 16385));
            default: step = StepW'($urandom_range(16384, 64));
          endcase
          case ($urandom_range(9))
            0: fpb = 0;
            1: fpb = CountW'($urandom_range(8191, 4096));
            default: fpb = CountW'($urandom_range(64, 1));
          endcase
        end
      endcase
      steady = (phase == 4 || phase == 5);
      apply_setting(stereo, step, fpb);
      for (int k = 0; k < ItemsPerPhase; k++) begin
        bs = (k == 0) || ($urandom_range(99) < 6);
        offer_frame(pick_sample(), pick_sample(), bs, n, first);
      end
      settle();
    end
    steady = 1'b0;

    if (mismatches == 0) begin
      $display("linear_interp_pitch_resampler_tb passed");
    end else begin
      $display("linear_interp_pitch_resampler_tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/lirp_pkg.sv
src/lirp_ctrl.sv
src/lirp_dp.sv
src/linear_interp_pitch_resampler.sv
verif/linear_interp_pitch_resampler_tb.sv
